/* design/irmst_pkg.sv */
// Package for the infrared mark/space transmitter.
// Holds the input and result word types and the sample-unit scale.
// No dependencies.
package irmst_pkg;

	// Carrier cycles per duration unit.
	localparam int unsigned SAMPLE_UNITS = 1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef struct packed {
		logic       command;
		logic [7:0] duration;
		logic       first;
		logic       last;
	} irmst_in_t;

	typedef struct packed {
		logic pin_level;
		logic segment_done;
		logic sequence_done;
		logic busy_res;
		logic rejected;
	} irmst_out_t;

endpackage

/* design/ir_mark_space_transmitter_top.sv */
// Infrared mark/space transmitter, top level.
// The result word of an accepted input word is registered and is valid in the cycle after acceptance.
// Throughput: one word per cycle while out_ready is high; the result register frees itself when taken.
// Reset (arst_n low): idle, pin low, next segment a mark, carrier_period 26.
// Depends on irmst_pkg.
module ir_mark_space_transmitter_top
	import irmst_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  irmst_in_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output irmst_out_t out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic [7:0]  carrier_period_q;
	logic [15:0] cycles_left_q;
	logic [7:0]  tick_count_q;
	logic        in_mark_q;
	logic        carrier_high_q;
	logic        playing_q;
	logic        final_segment_q;
	logic        out_valid_q;
	irmst_out_t  out_data_q;

	logic [15:0] cycles_left_d;
	logic [7:0]  tick_count_d;
	logic        in_mark_d;
	logic        carrier_high_d;
	logic        playing_d;
	logic        final_segment_d;
	irmst_out_t  result_d;

	logic        accept;
	logic [6:0]  phase_ticks;
	logic [7:0]  space_ticks;
	logic [8:0]  tick_inc;
	logic [15:0] load_cycles;
	logic [15:0] cycles_dec;
	logic        cycle_end;
	logic        finish;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// A period of 0 or 1 still gives each phase one tick.
	assign phase_ticks = (carrier_period_q[7:1] == 7'd0) ? 7'd1 : carrier_period_q[7:1];
	assign space_ticks = (carrier_period_q == 8'd0) ? 8'd1 : carrier_period_q;
	assign tick_inc    = {1'b0, tick_count_q} + 9'd1;
	assign load_cycles = 16'(in_data.duration * 16'(SAMPLE_UNITS));
	assign cycles_dec  = cycles_left_q - 16'd1;

	always_comb begin
		cycles_left_d   = cycles_left_q;
		tick_count_d    = tick_count_q;
		in_mark_d       = in_mark_q;
		carrier_high_d  = carrier_high_q;
		playing_d       = playing_q;
		final_segment_d = final_segment_q;
		result_d        = '0;
		cycle_end       = 1'b0;
		finish          = 1'b0;

		if (in_data.command == CMD_LOAD) begin
			if (playing_q) begin
				result_d.rejected = 1'b1;
			end else begin
				if (in_data.first) begin
					in_mark_d = 1'b1;
				end
				final_segment_d = in_data.last;
				tick_count_d    = 8'd0;
				cycles_left_d   = load_cycles;
				if (load_cycles == 16'd0) begin
					finish = 1'b1;
				end else begin
					playing_d      = 1'b1;
					carrier_high_d = in_mark_d;
				end
			end
		end else if (playing_q) begin
			if (in_mark_q) begin
				cycle_end = tick_inc >= {1'b0, phase_ticks, 1'b0};
			end else begin
				cycle_end = tick_inc >= {1'b0, space_ticks};
			end
			if (cycle_end) begin
				tick_count_d  = 8'd0;
				cycles_left_d = cycles_dec;
				if (cycles_dec == 16'd0) begin
					finish = 1'b1;
				end else begin
					carrier_high_d = in_mark_q;
				end
			end else begin
				tick_count_d = tick_inc[7:0];
				// Second half of a mark cycle drops the carrier.
				if (in_mark_q && tick_inc >= {2'b00, phase_ticks}) begin
					carrier_high_d = 1'b0;
				end
			end
		end

		if (finish) begin
			playing_d             = 1'b0;
			carrier_high_d        = 1'b0;
			tick_count_d          = 8'd0;
			cycles_left_d         = 16'd0;
			result_d.segment_done = 1'b1;
			if (final_segment_d) begin
				result_d.sequence_done = 1'b1;
				in_mark_d              = 1'b1;
				final_segment_d        = 1'b0;
			end else begin
				in_mark_d = !in_mark_d;
			end
		end

		result_d.pin_level = playing_d && in_mark_d && carrier_high_d;
		result_d.busy_res  = playing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carrier_period_q <= 8'd26;
			cycles_left_q    <= 16'd0;
			tick_count_q     <= 8'd0;
			in_mark_q        <= 1'b1;
			carrier_high_q   <= 1'b0;
			playing_q        <= 1'b0;
			final_segment_q  <= 1'b0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				carrier_period_q <= cfg_data;
			end
			if (accept) begin
				cycles_left_q   <= cycles_left_d;
				tick_count_q    <= tick_count_d;
				in_mark_q       <= in_mark_d;
				carrier_high_q  <= carrier_high_d;
				playing_q       <= playing_d;
				final_segment_q <= final_segment_d;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= result_d;
		end
	end

	// A rejected load only happens while a segment plays.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.rejected |-> out_data_q.busy_res)
		else $error("rejected word without busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.sequence_done |-> out_data_q.segment_done)
		else $error("sequence done without segment done");

	assert property (@(posedge clk) disable iff (!arst_n)
		!playing_q |-> !carrier_high_q && tick_count_q == 8'd0 && cycles_left_q == 16'd0)
		else $error("idle with live segment state");

	// The pin is only high while a mark segment is playing.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_data_q.pin_level |-> out_data_q.busy_res && in_mark_q)
		else $error("pin high outside a mark");

endmodule

/* dv/ir_mark_space_transmitter_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the infrared mark/space transmitter top level.
// Drives tick and load words through valid/ready and checks every result word against a scripted or predicted one.
// Depends on irmst_pkg and ir_mark_space_transmitter_top.
module ir_mark_space_transmitter_top_tb;
	import irmst_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES = 150;

	typedef struct packed {
		irmst_in_t  w;
		logic       typed;
		irmst_out_t r;
		logic       run_out;
	} step_row_t;

	// Expected words are {pin_level, segment_done, sequence_done, busy_res, rejected}.
	localparam step_row_t SCRIPT [16] = '{
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b1, 5'b00000, 1'b0},
		'{'{CMD_LOAD, 8'd0,   1'b1, 1'b1}, 1'b1, 5'b01100, 1'b0},
		'{'{CMD_LOAD, 8'd0,   1'b0, 1'b0}, 1'b1, 5'b01000, 1'b0},
		'{'{CMD_LOAD, 8'd0,   1'b0, 1'b1}, 1'b1, 5'b01100, 1'b0},
		'{'{CMD_LOAD, 8'd1,   1'b0, 1'b0}, 1'b1, 5'b10010, 1'b0},
		'{'{CMD_LOAD, 8'd255, 1'b1, 1'b1}, 1'b1, 5'b10011, 1'b0},
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b0, 5'b00000, 1'b0},
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b0, 5'b00000, 1'b1},
		'{'{CMD_LOAD, 8'd2,   1'b0, 1'b1}, 1'b1, 5'b00010, 1'b0},
		'{'{CMD_LOAD, 8'd0,   1'b0, 1'b0}, 1'b1, 5'b00011, 1'b0},
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b0, 5'b00000, 1'b1},
		'{'{CMD_LOAD, 8'd2,   1'b1, 1'b0}, 1'b1, 5'b10010, 1'b0},
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b0, 5'b00000, 1'b1},
		'{'{CMD_LOAD, 8'd0,   1'b1, 1'b1}, 1'b1, 5'b01100, 1'b0},
		'{'{CMD_TICK, 8'd0,   1'b0, 1'b0}, 1'b1, 5'b00000, 1'b0},
		'{'{CMD_TICK, 8'hFF,  1'b1, 1'b1}, 1'b1, 5'b00000, 1'b0}
	};

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	irmst_in_t  in_data;
	logic       out_valid;
	logic       out_ready;
	irmst_out_t out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// Transmitter state as the bench expects it.
	logic [7:0]  period_q = 8'd26;
	logic [15:0] cyc_left = '0;
	logic [7:0]  tick_in_cycle = '0;
	bit          mark_now = 1'b1;
	bit          carrier_up = 1'b0;
	bit          segment_on = 1'b0;
	bit          final_on = 1'b0;

	irmst_out_t expected_q [$];
	int mismatches = 0;
	int words_checked = 0;
	int sequences_seen = 0;
	int loads_turned_away = 0;
	int idle_cycles = 0;
	int hold_asks = 0;
	bit steady = 1'b0;

	always #6 clk = ~clk;

	ir_mark_space_transmitter_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	task automatic report_error(string msg);
		$display("mismatch at word %0d: %s", words_checked, msg);
		mismatches++;
	endtask

	task automatic check_field(string field, logic got, logic want);
		if (got !== want) begin
			report_error($sformatf("%s got %b, expected %b", field, got, want));
		end
	endtask

	function automatic void close_segment(inout irmst_out_t res);
		segment_on = 1'b0;
		carrier_up = 1'b0;
		tick_in_cycle = '0;
		cyc_left = '0;
		res.segment_done = 1'b1;
		if (final_on) begin
			res.sequence_done = 1'b1;
			mark_now = 1'b1;
			final_on = 1'b0;
		end else begin
			mark_now = !mark_now;
		end
	endfunction

	function automatic irmst_out_t carrier_step(irmst_in_t w);
		irmst_out_t res;
		int unsigned t;
		int unsigned half;
		bit wrap;
		res = '0;
		wrap = 1'b0;
		if (w.command == CMD_LOAD) begin
			if (segment_on) begin
				res.rejected = 1'b1;
			end else begin
				if (w.first) begin
					mark_now = 1'b1;
				end
				final_on = w.last;
				tick_in_cycle = '0;
				cyc_left = 16'(w.duration * SAMPLE_UNITS);
				if (cyc_left == 0) begin
					close_segment(res);
				end else begin
					segment_on = 1'b1;
					carrier_up = mark_now;
				end
			end
		end else if (segment_on) begin
			t = tick_in_cycle + 1;
			if (mark_now) begin
				// Periods below two still give each mark phase one tick.
				half = (period_q < 2) ? 1 : period_q / 2;
				if (t >= 2 * half) begin
					wrap = 1'b1;
				end else if (t >= half) begin
					carrier_up = 1'b0;
				end
			end else begin
				wrap = t >= ((period_q == 0) ? 1 : period_q);
			end
			if (wrap) begin
				tick_in_cycle = '0;
				cyc_left = cyc_left - 1'b1;
				if (cyc_left == 0) begin
					close_segment(res);
				end else begin
					carrier_up = mark_now;
				end
			end else begin
				tick_in_cycle = 8'(t);
			end
		end
		res.pin_level = segment_on && mark_now && carrier_up;
		res.busy_res = segment_on;
		return res;
	endfunction

	// Offers one word, holds it until taken, then records what it should produce.
	task automatic send_word(irmst_in_t w, bit use_typed, irmst_out_t typed);
		irmst_out_t pred;
		if (!steady && $urandom_range(99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pred = carrier_step(w);
		expected_q.push_back(use_typed ? typed : pred);
		if (pred.sequence_done) begin
			sequences_seen++;
		end
		if (pred.rejected) begin
			loads_turned_away++;
		end
	endtask

	task automatic run_out_segment();
		irmst_in_t w;
		while (segment_on) begin
			w = '{CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom)};
			send_word(w, 1'b0, '0);
		end
	endtask

	task automatic await_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_period(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		period_q = value;
	endtask

	// Mostly well-formed sequences: a load, ticks until the segment ends, the next load.
	// Around them go idle ticks, stray loads and loads that hit a busy segment.
	task automatic play_random(int budget);
		irmst_in_t w;
		int counted;
		int pick;
		bit open_seq;
		bit ignored;
		counted = 0;
		open_seq = 1'b0;
		while (counted < budget) begin
			w = '{CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom)};
			if (segment_on) begin
				w.command = ($urandom_range(99) < 8) ? CMD_LOAD : CMD_TICK;
			end else begin
				if ($urandom_range(99) < 12) begin
					w.command = 1'($urandom);
				end else begin
					w.command = CMD_LOAD;
					w.first = !open_seq || $urandom_range(99) < 5;
					w.last = $urandom_range(99) < 25;
				end
				// Long periods get short segments so the run stays bounded.
				pick = $urandom_range(99);
				if (pick < 8) begin
					w.duration = 8'd0;
				end else if (pick < 13 && period_q <= 3) begin
					w.duration = 8'($urandom_range(0, 255));
				end else if (period_q > 8) begin
					w.duration = 8'($urandom_range(1, 2));
				end else begin
					w.duration = 8'($urandom_range(1, 6));
				end
			end
			ignored = (w.command == CMD_TICK) ? !segment_on : segment_on;
			send_word(w, 1'b0, '0);
			if (!ignored) begin
				counted++;
				if (w.command == CMD_LOAD) begin
					open_seq = !w.last;
				end
			end
		end
	endtask

	// Result side: random stalls, one long hold-off on request, and the check.
	initial begin
		irmst_out_t want;
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_error("result word arrived with nothing expected");
				end else begin
					want = expected_q.pop_front();
					check_field("pin_level", out_data.pin_level, want.pin_level);
					check_field("segment_done", out_data.segment_done, want.segment_done);
					check_field("sequence_done", out_data.sequence_done, want.sequence_done);
					check_field("busy_res", out_data.busy_res, want.busy_res);
					check_field("rejected", out_data.rejected, want.rejected);
					words_checked++;
				end
			end
			if (hold_served != hold_asks) begin
				hold_served = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= steady || $urandom_range(99) >= 16;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", idle_cycles);
				$display("tb: failure");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		logic [7:0] periods [7];
		int budgets [7];
		periods = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd0, 8'd0};
		budgets = '{100, 100, 200, 150, 450, 100, 100};
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs at the reset carrier period.
		foreach (SCRIPT[i]) begin
			send_word(SCRIPT[i].w, SCRIPT[i].typed, SCRIPT[i].r);
			if (SCRIPT[i].run_out) begin
				run_out_segment();
			end
		end
		run_out_segment();
		await_results();
		play_random(100);
		run_out_segment();
		await_results();

		for (int i = 0; i < 7; i++) begin
			if (i >= 5) begin
				periods[i] = 8'($urandom_range(4, 40));
			end
			write_period(periods[i]);
			steady = (periods[i] == 8'd3);
			if (periods[i] == 8'd2) begin
				hold_asks++;
			end
			play_random(budgets[i]);
			run_out_segment();
			await_results();
		end
		steady = 1'b0;

		repeat (8) @(posedge clk);
		if (expected_q.size() != 0) begin
			report_error($sformatf("%0d result words never arrived", expected_q.size()));
		end
		$display("summary: %0d result words checked at carrier periods 0, 1, 2, 3, 26, 255, %0d and %0d",
			words_checked, periods[5], periods[6]);
		$display("summary: %0d sequences completed, %0d loads turned away while a segment played",
			sequences_seen, loads_turned_away);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

/* files.f */
design/irmst_pkg.sv
design/ir_mark_space_transmitter_top.sv
dv/ir_mark_space_transmitter_top_tb.sv
